// ===== rtl/sha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions of the sha-256 stream hasher
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic ReqAbsorb   = 1'b0;
  localparam logic ReqFinalize = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  typedef logic [7:0][31:0] hash_t;

  localparam hash_t InitHash = {
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sha_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_fifo
// short register queue between the input front and the compression back end
// ----------------------------------------------------------------------------
module sha_fifo
  import sha_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr_en,
  input  wire in_word_t wr_data,
  output logic          full,
  input  wire logic     rd_en,
  output in_word_t      rd_data,
  output logic          empty
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  in_word_t        mem [Depth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign full    = (count == (AW+1)'(Depth));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en && !empty) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(Depth)) else $error("queue count overflow");
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(full && empty)) else $error("queue full and empty");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !full && !rd_en) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

// ===== rtl/sha_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_core
// back end: block buffer, padding, one-round-per-cycle compression, digest out
// ----------------------------------------------------------------------------
module sha_core
  import sha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_word_t req,
  input  wire logic     req_valid,
  output logic          req_take,
  output out_word_t     result,
  output logic          empty,
  input  wire logic     pop
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StAdd   = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  logic [2:0]        state;
  logic [15:0][31:0] w;          // message schedule window, w[0] oldest
  logic [5:0]        fill;
  logic [63:0]       bit_len;
  hash_t             h;
  hash_t             v;
  logic [5:0]        rnd;
  logic              final_blk;  // current compression ends the message
  logic              more_pad;   // a second padding block follows
  logic [2:0]        emit_idx;

  // byte write into the schedule window, big-endian in each word
  function automatic logic [15:0][31:0] put_byte(input logic [15:0][31:0] win,
                                                  input logic [5:0] pos,
                                                  input logic [7:0] b);
    logic [15:0][31:0] r;
    r = win;
    r[pos[5:2]][8*(3-pos[1:0]) +: 8] = b;
    return r;
  endfunction

  logic [31:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2;
  always_comb begin
    s0    = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
    s1    = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    big1  = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1    = v[7] + big1 + ch + round_k(rnd) + w[0];
    big0  = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2    = big0 + maj;
  end

  // zero the bytes from pos onward, pos is 1..64 as called here
  function automatic logic [15:0][31:0] clear_from(input logic [15:0][31:0] win,
                                                    input logic [6:0] pos);
    logic [15:0][31:0] r;
    r = win;
    for (int i = 0; i < 64; i++) begin
      if (7'(i) >= pos) r[i/4][8*(3-(i%4)) +: 8] = 8'h00;
    end
    return r;
  endfunction

  assign req_take = (state == StIdle) && req_valid;
  assign empty    = (state != StEmit);
  assign result.digest_word = h[emit_idx];
  assign result.word_index  = emit_idx;
  assign result.last_word   = (emit_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      fill      <= '0;
      bit_len   <= '0;
      h         <= InitHash;
      rnd       <= '0;
      final_blk <= 1'b0;
      more_pad  <= 1'b0;
      emit_idx  <= '0;
    end else begin
      case (state)
        StIdle: begin
          if (req_valid) begin
            if (req.req_type == ReqAbsorb) begin
              w       <= put_byte(w, fill, req.data_byte);
              fill    <= fill + 1'b1;
              bit_len <= bit_len + 64'd8;
              if (fill == 6'd63) begin
                v         <= h;
                rnd       <= '0;
                final_blk <= 1'b0;
                state     <= StRound;
              end
            end else begin
              w         <= clear_from(put_byte(w, fill, PadByte), {1'b0, fill} + 7'd1);
              more_pad  <= (fill > 6'd55);
              final_blk <= (fill <= 6'd55);
              state     <= StPad;
            end
          end
        end
        StPad: begin
          // length goes in when this block is the last
          if (final_blk) begin
            w[14] <= bit_len[63:32];
            w[15] <= bit_len[31:0];
          end
          v     <= h;
          rnd   <= '0;
          state <= StRound;
        end
        StRound: begin
          w   <= {w_new, w[15:1]};
          v   <= {v[6:4], v[3] + t1, v[2:0], t1 + t2};
          rnd <= rnd + 1'b1;
          if (rnd == 6'd63) state <= StAdd;
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          fill <= '0;
          if (more_pad) begin
            more_pad  <= 1'b0;
            final_blk <= 1'b1;
            w         <= '0;
            state     <= StPad;
          end else if (final_blk) begin
            emit_idx <= '0;
            state    <= StEmit;
          end else begin
            state <= StIdle;
          end
        end
        StEmit: begin
          if (pop) begin
            emit_idx <= emit_idx + 1'b1;
            if (emit_idx == 3'd7) begin
              h         <= InitHash;
              bit_len   <= '0;
              fill      <= '0;
              final_blk <= 1'b0;
              state     <= StIdle;
            end
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    req_take |-> state == StIdle) else $error("request taken while busy");
  a_round_exit: assert property (@(posedge clk) disable iff (rst)
    (state == StRound && rnd == 6'd63) |=> state == StAdd)
    else $error("compression did not end after 64 rounds");
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (state == StEmit && pop && emit_idx == 3'd7) |=> state == StIdle && h == InitHash)
    else $error("hash not restored after digest");
`endif

endmodule

`default_nettype wire

// ===== rtl/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// streaming sha-256 over a byte stream, digest out as eight 32-bit words
// ----------------------------------------------------------------------------
// usage
//   input queue side: drive in_word and raise push while full is low; a word
//   with req_type absorb carries one message byte, req_type finalize pads the
//   message and makes the block emit the digest
//   output queue side: while empty is low, out_word holds the oldest digest
//   word; pop takes it; eight words per finalize, last_word on index 7
// timing
//   an absorb writes its byte into the block buffer; every 64th byte also
//   starts a compression, one round per cycle followed by the hash add
//   a finalize pads and compresses one block, or two if padding needs it,
//   then the digest words stream out one per cycle as fast as pop allows
//   a small input queue lets bytes be pushed while a compression is running
// reset
//   rst clears the queue, byte count and bit length and loads the initial
//   hash; if pop stays low the back end holds and the queue fills, then full
// ----------------------------------------------------------------------------
module sha256_stream_hasher
  import sha_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_word_t in_word,
  input  wire logic     push,
  output logic          full,
  output out_word_t     out_word,
  output logic          empty,
  input  wire logic     pop
);
  in_word_t q_data;
  logic     q_empty;
  logic     q_take;

  // front: queue of incoming words
  sha_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (in_word),
    .full    (full),
    .rd_en   (q_take),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // back: buffer, padding, compression and digest
  sha_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (q_data),
    .req_valid (!q_empty),
    .req_take  (q_take),
    .result    (out_word),
    .empty     (empty),
    .pop       (pop)
  );

`ifndef ASSERT_OFF
  a_take_has_data: assert property (@(posedge clk) disable iff (rst)
    q_take |-> !q_empty) else $error("back end took from empty queue");
  a_no_take_emit: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !q_take) else $error("request taken during digest output");
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_word.last_word == (out_word.word_index == 3'd7)))
    else $error("last marker mismatch");
`endif

endmodule

`default_nettype wire
